>>> src/pgw_pkg.sv
`timescale 1ns / 1ps

package pgw_pkg;

	localparam int unsigned VA_W   = 48;
	localparam int unsigned PA_W   = 52;
	localparam int unsigned DATA_W = 64;
	localparam int unsigned IDX_W  = 9;

	// func codes
	localparam logic FUNC_XLATE = 1'b0;
	localparam logic FUNC_ENTRY = 1'b1;

	// kind codes
	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	// walk levels
	localparam logic [1:0] LVL_PT   = 2'd0;
	localparam logic [1:0] LVL_PD   = 2'd1;
	localparam logic [1:0] LVL_PDPT = 2'd2;
	localparam logic [1:0] LVL_TOP  = 2'd3;

	localparam int unsigned BIT_PRESENT = 0;
	localparam int unsigned BIT_HUGE    = 7;

	typedef struct packed {
		logic              func;
		logic [VA_W-1:0]   virt_addr;
		logic [DATA_W-1:0] read_data;
	} in_word_t;

	typedef struct packed {
		logic            kind;
		logic [PA_W-1:0] read_addr;
		logic [PA_W-1:0] phys_addr;
		logic            fault;
	} out_word_t;

	typedef struct packed {
		logic            walking;
		logic [1:0]      level;
		logic [VA_W-1:0] held_virt;
	} walk_state_t;

	function automatic logic [IDX_W-1:0] level_index(logic [VA_W-1:0] va, logic [1:0] lvl);
		logic [IDX_W-1:0] idx;
		unique case (lvl)
			LVL_PT:   idx = va[20:12];
			LVL_PD:   idx = va[29:21];
			LVL_PDPT: idx = va[38:30];
			default:  idx = va[47:39];
		endcase
		return idx;
	endfunction

endpackage

>>> src/pgw_step.sv
`timescale 1ns / 1ps

module pgw_step (
	input  pgw_pkg::in_word_t    item,
	input  pgw_pkg::walk_state_t st,
	input  logic [pgw_pkg::PA_W-1:0] root,
	output pgw_pkg::walk_state_t st_next,
	output logic                 has_res,
	output pgw_pkg::out_word_t   res
);

	logic [pgw_pkg::DATA_W-1:0] entry;
	logic [1:0]                 lvl_dn;

	assign entry  = item.read_data;
	assign lvl_dn = st.level - 2'd1;

	always_comb begin
		st_next = st;
		has_res = 1'b0;
		res     = '0;
		if (item.func == pgw_pkg::FUNC_XLATE) begin
			if (!st.walking) begin
				st_next.walking   = 1'b1;
				st_next.level     = pgw_pkg::LVL_TOP;
				st_next.held_virt = item.virt_addr;
				has_res           = 1'b1;
				res.kind          = pgw_pkg::KIND_READ;
				res.read_addr     = {root[51:12],
					pgw_pkg::level_index(item.virt_addr, pgw_pkg::LVL_TOP), 3'b000};
			end
		end else if (st.walking) begin
			has_res = 1'b1;
			if (!entry[pgw_pkg::BIT_PRESENT]) begin
				st_next.walking = 1'b0;
				st_next.level   = pgw_pkg::LVL_PT;
				res.kind        = pgw_pkg::KIND_DONE;
				res.fault       = 1'b1;
			end else if (st.level == pgw_pkg::LVL_PD && entry[pgw_pkg::BIT_HUGE]) begin
				// 2 MiB page: frame from bits 51:21
				st_next.walking = 1'b0;
				st_next.level   = pgw_pkg::LVL_PT;
				res.kind        = pgw_pkg::KIND_DONE;
				res.phys_addr   = {entry[51:21], st.held_virt[20:0]};
			end else if (st.level == pgw_pkg::LVL_PT) begin
				st_next.walking = 1'b0;
				res.kind        = pgw_pkg::KIND_DONE;
				res.phys_addr   = {entry[51:12], st.held_virt[11:0]};
			end else begin
				st_next.level = lvl_dn;
				res.kind      = pgw_pkg::KIND_READ;
				res.read_addr = {entry[51:12],
					pgw_pkg::level_index(st.held_virt, lvl_dn), 3'b000};
			end
		end
	end

endmodule

>>> src/pgw_out_reg.sv
`timescale 1ns / 1ps

module pgw_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  pgw_pkg::out_word_t din,
	output logic               room,
	output logic               res_valid,
	input  logic               res_stall,
	output pgw_pkg::out_word_t res
);

	logic               valid_q;
	pgw_pkg::out_word_t word_q;

	// free when empty or when the held word leaves this cycle
	assign room      = !valid_q || !res_stall;
	assign res_valid = valid_q;
	assign res       = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (room) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (room && load) begin
			word_q <= din;
		end
	end

endmodule

>>> src/four_level_page_walker_core.sv
`timescale 1ns / 1ps
// Result path: an accepted item word is registered in stage one, and its result
// word in the output register. Throughput: one item word per cycle while res_stall
// does not hold a result word in the output register.
// Stalls: the input stalls only while a result word is held by res_stall.
// Reset: arst_n clears walk state, root base, input and output valids at once;
// payload registers are not reset.

module four_level_page_walker_core (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [pgw_pkg::PA_W-1:0] cfg_data,
	input  logic                     item_valid,
	output logic                     item_stall,
	input  pgw_pkg::in_word_t        item,
	output logic                     res_valid,
	input  logic                     res_stall,
	output pgw_pkg::out_word_t       res
);

	logic                     valid_s1;
	pgw_pkg::in_word_t        item_s1;
	logic [pgw_pkg::PA_W-1:0] root_q;
	pgw_pkg::walk_state_t     st_q;
	pgw_pkg::walk_state_t     st_next;
	logic                     has_res;
	pgw_pkg::out_word_t       res_next;
	logic                     room;
	logic                     adv;

	assign adv        = valid_s1 && room;
	assign item_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q <= '0;
		end else if (cfg_we) begin
			root_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (adv) begin
			st_q <= st_next;
		end
	end

	pgw_step u_step (
		.item    (item_s1),
		.st      (st_q),
		.root    (root_q),
		.st_next (st_next),
		.has_res (has_res),
		.res     (res_next)
	);

	pgw_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv && has_res),
		.din       (res_next),
		.room      (room),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	// an idle walker always sits at the page-table level
	a_idle_level: assert property (@(posedge clk) disable iff (!arst_n)
		!st_q.walking |-> st_q.level == pgw_pkg::LVL_PT)
		else $error("idle walker with nonzero level");

	// hold a stalled input word in stage one
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |=> valid_s1 && $stable(item_s1))
		else $error("stage one word lost under stall");

	// a finished walk leaves the walker idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		adv && has_res && res_next.kind == pgw_pkg::KIND_DONE |=> !st_q.walking)
		else $error("walker still busy after finish");

	// a read request always leaves a walk in progress
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		adv && has_res && res_next.kind == pgw_pkg::KIND_READ |=> st_q.walking)
		else $error("read issued while idle");

endmodule
